// ----- rtl/running_median_two_heaps_macros.svh -----
// Assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`ifndef SYNTHESIS
`define RMH_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define RMH_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define RMH_ASSERT_IMP(label, clk, rst_n, a, b)
`define RMH_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/rmh_pkg.sv -----
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared widths, command and status types for the running median block.
// ----------------------------------------------------------------------------
`default_nettype none
package rmh_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int VALUE_BITS = 30;
    localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
    localparam int CNT_BITS   = ADDR_BITS + 1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_WR,
        OP_UP_RD,
        OP_UP_CMP,
        OP_TOPS_RD,
        OP_TOPS_CMP,
        OP_DN_RD,
        OP_DN_RD2,
        OP_DN_CMP,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_upper;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic to_upper;
        logic up_more;
        logic swap;
        logic dn_more;
        logic odd;
    } t_status;
endpackage
`default_nettype wire

// ----- rtl/rmh_datapath.sv -----
// ----------------------------------------------------------------------------
// rmh_datapath
// Heap memories, counts, sift index and compare logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_median_two_heaps_macros.svh"
module rmh_datapath
    import rmh_pkg::*;
(
    input  wire  logic    i_clk,
    input  wire  logic    i_rst_n,
    input  wire  t_value  i_value,
    input  wire  logic    i_restart,
    input  wire  t_cmd    i_cmd,
    output       t_status o_status,
    output       t_value  o_median
);
    t_value r_low_mem [HEAP_DEPTH];
    t_value r_up_mem  [HEAP_DEPTH];
    t_cnt   r_lcnt, r_ucnt, n_lcnt, n_ucnt;
    t_cnt   r_idx;
    t_value r_v;
    t_value r_a, r_b, r_c;
    t_value r_ltop, r_utop;
    t_cnt   r_n;

    t_cnt  par, lch, rch, best_i;
    t_value best_v;
    logic  is_max, a_over;
    logic  has_l, has_r;

    function automatic logic above(input t_value a, input t_value b, input logic mx);
        above = mx ? (a > b) : (a < b);
    endfunction

    always_comb begin
        n_lcnt = i_restart ? '0 : r_lcnt;
        n_ucnt = i_restart ? '0 : r_ucnt;
    end

    assign par    = (r_idx - t_cnt'(1)) >> 1;
    assign lch    = {r_idx[CNT_BITS-2:0], 1'b1};
    assign rch    = lch + t_cnt'(1);
    assign is_max = !i_cmd.sel_upper;
    assign a_over = above(r_v, r_a, is_max);
    assign has_l  = lch < r_n;
    assign has_r  = has_l && (rch < r_n);

    always_comb begin
        best_v = r_v;
        best_i = r_idx;
        if (has_l && above(r_a, best_v, is_max)) begin
            best_v = r_a;
            best_i = lch;
        end
        if (has_r && above(r_b, best_v, is_max)) begin
            best_v = r_b;
            best_i = rch;
        end
    end

    always_comb begin
        o_status.to_upper = (r_lcnt == r_ucnt);
        o_status.full     = (o_status.to_upper ? r_ucnt : r_lcnt) >= t_cnt'(HEAP_DEPTH);
        o_status.up_more  = (r_idx != '0) && a_over;
        o_status.swap     = (r_lcnt != '0) && (r_ucnt != '0) && (r_utop < r_ltop);
        o_status.dn_more  = (best_i != r_idx);
        o_status.odd      = r_lcnt[0] ^ r_ucnt[0];
    end
    assign o_median = r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= '0;
            r_ucnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_lcnt <= n_lcnt;
                    r_ucnt <= n_ucnt;
                    r_v    <= i_value;
                end
                OP_PUSH_WR: begin
                    if (i_cmd.sel_upper) begin
                        r_up_mem[r_ucnt[ADDR_BITS-1:0]] <= r_v;
                        r_idx  <= r_ucnt;
                        r_ucnt <= r_ucnt + t_cnt'(1);
                    end else begin
                        r_low_mem[r_lcnt[ADDR_BITS-1:0]] <= r_v;
                        r_idx  <= r_lcnt;
                        r_lcnt <= r_lcnt + t_cnt'(1);
                    end
                end
                OP_UP_RD: begin
                    r_a <= i_cmd.sel_upper ? r_up_mem[par[ADDR_BITS-1:0]]
                                           : r_low_mem[par[ADDR_BITS-1:0]];
                end
                OP_UP_CMP: begin
                    if (o_status.up_more) begin
                        if (i_cmd.sel_upper) begin
                            r_up_mem[par[ADDR_BITS-1:0]]   <= r_v;
                        end else begin
                            r_low_mem[par[ADDR_BITS-1:0]]  <= r_v;
                        end
                        r_idx <= par;
                    end
                    if (i_cmd.sel_upper) begin
                        r_up_mem[r_idx[ADDR_BITS-1:0]] <= o_status.up_more ? r_a : r_v;
                    end else begin
                        r_low_mem[r_idx[ADDR_BITS-1:0]] <= o_status.up_more ? r_a : r_v;
                    end
                end
                OP_TOPS_RD: begin
                    r_utop <= r_up_mem[0];
                    r_ltop <= r_low_mem[0];
                end
                OP_TOPS_CMP: begin
                    if (o_status.swap) begin
                        r_up_mem[0]  <= r_ltop;
                        r_low_mem[0] <= r_utop;
                    end
                    r_c <= o_status.swap ? r_ltop : r_utop;
                    r_idx <= '0;
                end
                OP_DN_RD: begin
                    r_n <= i_cmd.sel_upper ? r_ucnt : r_lcnt;
                    r_v <= i_cmd.sel_upper ? r_up_mem[r_idx[ADDR_BITS-1:0]]
                                           : r_low_mem[r_idx[ADDR_BITS-1:0]];
                    r_a <= i_cmd.sel_upper ? r_up_mem[lch[ADDR_BITS-1:0]]
                                           : r_low_mem[lch[ADDR_BITS-1:0]];
                end
                OP_DN_RD2: begin
                    r_b <= i_cmd.sel_upper ? r_up_mem[rch[ADDR_BITS-1:0]]
                                           : r_low_mem[rch[ADDR_BITS-1:0]];
                end
                OP_DN_CMP: begin
                    if (o_status.dn_more) begin
                        if (i_cmd.sel_upper) begin
                            r_up_mem[r_idx[ADDR_BITS-1:0]]  <= best_v;
                            r_up_mem[best_i[ADDR_BITS-1:0]] <= r_v;
                        end else begin
                            r_low_mem[r_idx[ADDR_BITS-1:0]]  <= best_v;
                            r_low_mem[best_i[ADDR_BITS-1:0]] <= r_v;
                        end
                        r_idx <= best_i;
                    end else begin
                        r_idx <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `RMH_ASSERT_IMP(a_cnt_bal, i_clk, i_rst_n, 1'b1, (r_ucnt == r_lcnt) || (r_ucnt == r_lcnt + t_cnt'(1)))
    `RMH_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_ucnt <= t_cnt'(HEAP_DEPTH))
    `RMH_ASSERT_NXT(a_push_inc, i_clk, i_rst_n, i_cmd.op == OP_PUSH_WR, r_ucnt + r_lcnt == $past(r_ucnt + r_lcnt) + t_cnt'(1))
endmodule
`default_nettype wire

// ----- rtl/rmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmh_ctrl
// Sequencer for push and sift-up, top exchange and the two sift-down passes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_median_two_heaps_macros.svh"
module rmh_ctrl
    import rmh_pkg::*;
(
    input  wire  logic    i_clk,
    input  wire  logic    i_rst_n,
    input  wire  logic    start,
    output       logic    busy,
    input  wire  t_status i_status,
    output       t_cmd    o_cmd,
    output       logic    o_valid,
    output       logic    o_dropped
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_PUSH, S_URD, S_UCMP, S_TRD, S_TCMP,
        S_DRD, S_DRD2, S_DCMP, S_OUT
    } t_state;

    t_state r_state;
    logic   r_sel, r_second;

    always_comb begin
        o_cmd.sel_upper = r_sel;
        case (r_state)
            S_IDLE:  o_cmd.op = start ? OP_LOAD : OP_NONE;
            S_PUSH:  o_cmd.op = OP_PUSH_WR;
            S_URD:   o_cmd.op = OP_UP_RD;
            S_UCMP:  o_cmd.op = OP_UP_CMP;
            S_TRD:   o_cmd.op = OP_TOPS_RD;
            S_TCMP:  o_cmd.op = OP_TOPS_CMP;
            S_DRD:   o_cmd.op = OP_DN_RD;
            S_DRD2:  o_cmd.op = OP_DN_RD2;
            S_DCMP:  o_cmd.op = OP_DN_CMP;
            default: o_cmd.op = OP_NONE;
        endcase
    end
    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= 1'b0;
            r_second  <= 1'b0;
            o_valid   <= 1'b0;
            o_dropped <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (start) r_state <= S_CHECK;
                S_CHECK: begin
                    r_sel <= i_status.to_upper;
                    if (i_status.full) begin
                        o_valid   <= 1'b1;
                        o_dropped <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: r_state <= S_URD;
                S_URD:  r_state <= S_UCMP;
                S_UCMP: r_state <= i_status.up_more ? S_URD : S_TRD;
                S_TRD:  r_state <= S_TCMP;
                S_TCMP: begin
                    r_sel    <= 1'b1;
                    r_second <= 1'b0;
                    r_state  <= i_status.swap ? S_DRD : S_OUT;
                end
                S_DRD:  r_state <= S_DRD2;
                S_DRD2: r_state <= S_DCMP;
                S_DCMP: begin
                    if (i_status.dn_more) begin
                        r_state <= S_DRD;
                    end else if (!r_second) begin
                        r_second <= 1'b1;
                        r_sel    <= 1'b0;
                        r_state  <= S_DRD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid   <= i_status.odd;
                    o_dropped <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RMH_ASSERT_NXT(a_start_go, i_clk, i_rst_n, start && !busy, r_state == S_CHECK)
    `RMH_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, r_state == S_IDLE)
    `RMH_ASSERT_NXT(a_swap_sift, i_clk, i_rst_n, r_state == S_TCMP && i_status.swap, r_state == S_DRD)
endmodule
`default_nettype wire

// ----- rtl/running_median_two_heaps.sv -----
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over two heaps held in on-chip memory.
//
// Drive i_value and i_restart with start while busy is low; that beat is
// taken at the clock edge. busy stays high while the item is worked on.
// When the total held becomes odd, or the chosen heap is full, o_valid
// pulses for one cycle with o_median and o_dropped; it cannot be stalled.
// A dropped item leaves the heaps as they were and reports median 0.
// Sequence: the item is checked, written, sifted up (a read then a compare
// per level), the tops are read and compared, and after a top exchange
// each heap is sifted down (two reads then a compare per level, at least
// one check per heap); o_valid rises as the output state is left. A dropped
// item reports from the check state. busy falls with the result, so the
// next beat can be taken at the following edge.
// Reset empties both heaps at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module running_median_two_heaps
    import rmh_pkg::*;
(
    input  wire  logic   i_clk,
    input  wire  logic   i_rst_n,
    input  wire  logic   start,
    output       logic   busy,
    input  wire  t_value i_value,
    input  wire  logic   i_restart,
    output       logic   o_valid,
    output       t_value o_median,
    output       logic   o_dropped
);
    t_cmd    cmd;
    t_status status;
    t_value  med;

    rmh_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy,
        .i_status(status), .o_cmd(cmd), .o_valid, .o_dropped
    );

    rmh_datapath u_dp (
        .i_clk, .i_rst_n, .i_value, .i_restart,
        .i_cmd(cmd), .o_status(status), .o_median(med)
    );

    assign o_median = o_dropped ? '0 : med;
endmodule
`default_nettype wire

// ----- tb/tb_running_median_two_heaps.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps
// Self-checking bench for the two-heap running median.
//
// Walks a short table of directed samples, then random runs with the
// sender idle before 34, 87, then 0 percent of samples. Each accepted sample is fed to a local
// two-heap model; result beats are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_running_median_two_heaps;
    import rmh_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 100;
    localparam int RAND_RUN    = 392;

    typedef struct {
        t_value median;
        logic   dropped;
    } t_median_beat;

    typedef struct {
        t_value value;
        logic   restart;
        logic   typed;
        t_value want;
    } t_sample_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_value i_value;
    logic   i_restart;
    logic   o_valid;
    t_value o_median;
    logic   o_dropped;

    running_median_two_heaps dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_value   (i_value),
        .i_restart (i_restart),
        .o_valid   (o_valid),
        .o_median  (o_median),
        .o_dropped (o_dropped)
    );

    // index 0: lower half, max on top; index 1: upper half, min on top
    t_value       heap_mem [2][HEAP_DEPTH];
    int           heap_cnt [2];
    t_median_beat median_q [$];
    int           mismatches;
    int           beats_seen;
    int           drops_seen;
    int           samples_sent;
    int           cycles;
    int           idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic bit ranks_above(t_value a, t_value b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    function automatic void heap_insert(int h, t_value v);
        int     i;
        int     p;
        t_value t;
        i = heap_cnt[h];
        heap_mem[h][i] = v;
        heap_cnt[h] = i + 1;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_above(heap_mem[h][i], heap_mem[h][p], h == 0))
                break;
            t = heap_mem[h][i];
            heap_mem[h][i] = heap_mem[h][p];
            heap_mem[h][p] = t;
            i = p;
        end
    endfunction

    function automatic void heap_settle(int h);
        int     i;
        int     l;
        int     best;
        t_value t;
        i = 0;
        forever begin
            l = 2 * i + 1;
            best = i;
            if (l >= heap_cnt[h])
                break;
            if (ranks_above(heap_mem[h][l], heap_mem[h][best], h == 0))
                best = l;
            if (l + 1 < heap_cnt[h] &&
                ranks_above(heap_mem[h][l+1], heap_mem[h][best], h == 0))
                best = l + 1;
            if (best == i)
                break;
            t = heap_mem[h][i];
            heap_mem[h][i] = heap_mem[h][best];
            heap_mem[h][best] = t;
            i = best;
        end
    endfunction

    function automatic bit predict_median(t_value v, logic rs, output t_median_beat beat);
        int     dst;
        t_value t;
        if (rs) begin
            heap_cnt[0] = 0;
            heap_cnt[1] = 0;
        end
        dst = (heap_cnt[0] == heap_cnt[1]) ? 1 : 0;
        if (heap_cnt[dst] >= HEAP_DEPTH) begin
            beat.median  = '0;
            beat.dropped = 1'b1;
            return 1'b1;
        end
        heap_insert(dst, v);
        if (heap_cnt[0] > 0 && heap_cnt[1] > 0 && heap_mem[1][0] < heap_mem[0][0]) begin
            t = heap_mem[1][0];
            heap_mem[1][0] = heap_mem[0][0];
            heap_mem[0][0] = t;
            heap_settle(1);
            heap_settle(0);
        end
        beat.median  = heap_mem[1][0];
        beat.dropped = 1'b0;
        return ((heap_cnt[0] + heap_cnt[1]) % 2) != 0;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input t_value v, input logic rs, input bit typed,
                               input t_value want);
        int           gap;
        t_median_beat beat;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_value   <= v;
        i_restart <= rs;
        do @(posedge i_clk); while (busy);
        samples_sent++;
        if (predict_median(v, rs, beat)) begin
            if (typed && (beat.dropped || beat.median != want))
                report_mismatch("table row", beat.median, want);
            median_q.push_back(beat);
        end else if (typed) begin
            report_mismatch("table row gave no beat", 0, want);
        end
        @(negedge i_clk);
    endtask

    function automatic t_value rand_value();
        case ($urandom_range(3))
            0: return t_value'({$urandom, $urandom});
            1: return t_value'($urandom_range(15));
            2: return {VALUE_BITS{1'b1}} - t_value'($urandom_range(15));
            default: return t_value'($urandom_range(1000));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_median_beat want;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (o_dropped) drops_seen++;
            if (median_q.size() == 0) begin
                report_mismatch("unexpected beat, median", o_median, 0);
            end else begin
                want = median_q.pop_front();
                if (o_dropped !== want.dropped)
                    report_mismatch("dropped", o_dropped, want.dropped);
                if (o_median !== want.median)
                    report_mismatch("median", o_median, want.median);
            end
        end
    end

    localparam t_value VMAX = {VALUE_BITS{1'b1}};

    t_sample_row directed [] = '{
        '{30'd17,   1'b0, 1'b1, 30'd17},
        '{30'd0,    1'b1, 1'b1, 30'd0},
        '{VMAX,     1'b0, 1'b0, 30'd0},
        '{30'd5,    1'b0, 1'b0, 30'd0},
        '{VMAX,     1'b1, 1'b1, VMAX},
        '{30'd0,    1'b0, 1'b0, 30'd0},
        '{30'd0,    1'b0, 1'b0, 30'd0},
        '{30'd5,    1'b1, 1'b1, 30'd5},
        '{30'd3,    1'b0, 1'b0, 30'd0},
        '{30'd7,    1'b0, 1'b0, 30'd0},
        '{30'd1,    1'b0, 1'b0, 30'd0},
        '{30'd9,    1'b0, 1'b0, 30'd0},
        '{30'd4,    1'b0, 1'b0, 30'd0},
        '{30'd4,    1'b0, 1'b0, 30'd0},
        '{30'd4,    1'b0, 1'b0, 30'd0},
        '{30'd2,    1'b0, 1'b0, 30'd0},
        '{30'd8,    1'b0, 1'b0, 30'd0},
        '{30'h2AAAAAAA, 1'b1, 1'b1, 30'h2AAAAAAA},
        '{30'h15555555, 1'b0, 1'b0, 30'd0},
        '{30'd100,  1'b0, 1'b0, 30'd0},
        '{30'd50,   1'b0, 1'b0, 30'd0},
        '{30'd60,   1'b0, 1'b0, 30'd0}
    };

    initial begin
        int wait_cycles;
        cycles       = 0;
        mismatches   = 0;
        beats_seen   = 0;
        drops_seen   = 0;
        samples_sent = 0;
        heap_cnt[0]  = 0;
        heap_cnt[1]  = 0;
        idle_pct     = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_value      = '0;
        i_restart    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 34;
        foreach (directed[k])
            send_sample(directed[k].value, directed[k].restart,
                        directed[k].typed, directed[k].want);

        for (int n = 0; n < RAND_RUN; n++)
            send_sample(rand_value(), $urandom_range(39) == 0, 1'b0, '0);

        idle_pct = 87;
        for (int n = 0; n < RAND_RUN; n++)
            send_sample(rand_value(), $urandom_range(39) == 0, 1'b0, '0);

        idle_pct = 0;
        for (int n = 0; n < RAND_RUN; n++)
            send_sample(rand_value(), $urandom_range(39) == 0, 1'b0, '0);
        start <= 1'b0;

        wait_cycles = 0;
        while (median_q.size() != 0 && wait_cycles < 10000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Sent %0d samples, checked %0d result beats, %0d of them dropped.",
                 samples_sent, beats_seen, drops_seen);
        $display("Ran %0d cycles; %0d beats still awaited.", cycles, median_q.size());
        if (mismatches == 0 && median_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/rmh_pkg.sv
rtl/rmh_datapath.sv
rtl/rmh_ctrl.sv
rtl/running_median_two_heaps.sv
tb/tb_running_median_two_heaps.sv
